// ===== src/rcd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating clock divider package
// Shared types and constants for the rotating clock divider.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int OUTPUT_COUNT = 8;
    localparam int ROT_W        = $clog2(OUTPUT_COUNT);
    localparam int COUNT_W      = 9;
    localparam int TIME_W       = 16;

    localparam logic [COUNT_W-1:0] COUNT_WRAP        = 9'd288;
    localparam logic [TIME_W-1:0]  PULSE_WIDTH_RESET = 16'd1000;

    typedef logic [0:0]           t_cfg_index;
    typedef logic [TIME_W-1:0]    t_cfg_data;

    localparam t_cfg_index CFG_DIVIDE_MODE = 1'd0;
    localparam t_cfg_index CFG_PULSE_WIDTH = 1'd1;

    typedef enum logic {
        MODE_PPQN24  = 1'b0,
        MODE_LINEAR  = 1'b1
    } t_divide_mode;

    typedef struct packed {
        logic              clock_pulse;
        logic              rotate_gate;
        logic [TIME_W-1:0] time_step;
    } t_in_beat;

    typedef struct packed {
        logic [OUTPUT_COUNT-1:0] gates;
        logic [COUNT_W-1:0]      pulse_number;
    } t_out_beat;

endpackage

// ===== src/rcd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating clock divider stream interfaces
// Valid/ready channels for the input steps and the result beats.
// ----------------------------------------------------------------------------
interface rcd_in_if;
    import rcd_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rcd_out_if;
    import rcd_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/rotating_clock_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating clock divider
// Eight divided gate outputs from a master pulse, with rotation of outputs.
// ----------------------------------------------------------------------------
// Each input beat is one time step carrying the master pulse flag, the
// rotation gate level and the elapsed time in microseconds. Every input beat
// yields exactly one result beat with the eight gate levels and the current
// pulse count.
// The input beat is captured in an input register, then evaluated against
// the divider state and written to the result register once that register
// is free or its beat is being taken. One beat is accepted in every cycle
// while the receiver keeps up.
// When the receiver stalls, the result register holds its beat and the input
// register can still take one more beat; after that the input ready is low
// until the result is taken.
// The configuration port writes the divide mode and the pulse width; it is to
// be written only while no beat is in flight.
// Reset is synchronous and active low. It clears the pulse count, rotation,
// gates and timer, empties both registers, and sets the divide mode to 0 and
// the pulse width to 1000 microseconds.
// ----------------------------------------------------------------------------
module rotating_clock_divider (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  rcd_pkg::t_cfg_index i_cfg_index,
    input  rcd_pkg::t_cfg_data  i_cfg_data,
    rcd_in_if.sink              i_in,
    rcd_out_if.source           o_out
);
    import rcd_pkg::*;

    t_divide_mode            r_mode;
    logic [TIME_W-1:0]       r_pulse_width;

    logic                    r_in_valid;
    t_in_beat                r_in;
    logic                    r_out_valid;
    t_out_beat               r_out;

    logic [COUNT_W-1:0]      r_count;
    logic [ROT_W-1:0]        r_rotation;
    logic [OUTPUT_COUNT-1:0] r_gates;
    logic [TIME_W-1:0]       r_remaining;
    logic                    r_last_level;

    logic                    advance;
    logic [COUNT_W-1:0]      count_inc;
    logic [COUNT_W-1:0]      n_count;
    logic [ROT_W-1:0]        n_rotation;
    logic [OUTPUT_COUNT-1:0] n_gates;
    logic [TIME_W-1:0]       n_remaining;
    logic [OUTPUT_COUNT-1:0] calc_gates;

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    rcd_gate_calc u_gate_calc (
        .i_count    (n_count),
        .i_mode     (r_mode),
        .i_rotation (n_rotation),
        .o_gates    (calc_gates)
    );

    always_comb begin
        count_inc  = r_count + 9'd1;
        n_rotation = r_rotation;
        if (r_in.rotate_gate && !r_last_level) begin
            n_rotation = r_rotation + 3'd1;
        end
        n_count     = r_count;
        n_remaining = r_remaining;
        n_gates     = r_gates;
        if (r_in.clock_pulse) begin
            n_count     = (count_inc >= COUNT_WRAP) ? '0 : count_inc;
            n_remaining = r_pulse_width;
            n_gates     = calc_gates;
        end else begin
            if (r_remaining != '0) begin
                n_remaining = (r_in.time_step >= r_remaining) ? '0
                                                              : r_remaining - r_in.time_step;
            end
            if (n_remaining == '0) begin
                n_gates = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_PPQN24;
            r_pulse_width <= PULSE_WIDTH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIVIDE_MODE: r_mode <= t_divide_mode'(i_cfg_data[0]);
                CFG_PULSE_WIDTH: r_pulse_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_count      <= '0;
            r_rotation   <= '0;
            r_gates      <= '0;
            r_remaining  <= '0;
            r_last_level <= 1'b0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_count      <= n_count;
                r_rotation   <= n_rotation;
                r_gates      <= n_gates;
                r_remaining  <= n_remaining;
                r_last_level <= r_in.rotate_gate;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.gates        <= n_gates;
            r_out.pulse_number <= n_count;
        end
    end

endmodule

// ===== src/rcd_gate_calc.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating clock divider gate calculation
// Tests the pulse count against each output's divisor and rotates the result.
// ----------------------------------------------------------------------------
module rcd_gate_calc (
    input  logic [rcd_pkg::COUNT_W-1:0]      i_count,
    input  rcd_pkg::t_divide_mode            i_mode,
    input  logic [rcd_pkg::ROT_W-1:0]        i_rotation,
    output logic [rcd_pkg::OUTPUT_COUNT-1:0] o_gates
);
    import rcd_pkg::*;

    // Every power of four leaves a remainder of one by three, so the sum of the
    // two-bit digits keeps the remainder of the count.
    function automatic logic div_by_3(input logic [COUNT_W-1:0] v);
        logic [3:0] s;
        s = {2'b0, v[1:0]} + {2'b0, v[3:2]} + {2'b0, v[5:4]} + {2'b0, v[7:6]}
            + {3'b0, v[8]};
        return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9) || (s == 4'd12);
    endfunction

    // Every power of sixteen leaves a remainder of one by five.
    function automatic logic div_by_5(input logic [COUNT_W-1:0] v);
        logic [4:0] s;
        s = {1'b0, v[3:0]} + {1'b0, v[7:4]} + {4'b0, v[8]};
        return (s == 5'd0) || (s == 5'd5) || (s == 5'd10) || (s == 5'd15)
            || (s == 5'd20) || (s == 5'd25) || (s == 5'd30);
    endfunction

    // Every power of eight leaves a remainder of one by seven.
    function automatic logic div_by_7(input logic [COUNT_W-1:0] v);
        logic [4:0] s;
        s = {2'b0, v[2:0]} + {2'b0, v[5:3]} + {2'b0, v[8:6]};
        return (s == 5'd0) || (s == 5'd7) || (s == 5'd14) || (s == 5'd21);
    endfunction

    logic                    div3;
    logic                    div5;
    logic                    div7;
    logic [OUTPUT_COUNT-1:0] logical;
    logic [2*OUTPUT_COUNT-1:0] rotated;

    always_comb begin
        div3 = div_by_3(i_count);
        div5 = div_by_5(i_count);
        div7 = div_by_7(i_count);
        case (i_mode)
            MODE_PPQN24: begin
                logical[0] = 1'b1;
                logical[1] = (i_count[0] == 1'b0) && div3;
                logical[2] = (i_count[2:0] == 3'd0);
                logical[3] = (i_count[1:0] == 2'd0) && div3;
                logical[4] = (i_count[2:0] == 3'd0) && div3;
                logical[5] = (i_count[4:0] == 5'd0);
                logical[6] = (i_count[3:0] == 4'd0) && div3;
                logical[7] = (i_count[4:0] == 5'd0) && div3;
            end
            default: begin
                logical[0] = 1'b1;
                logical[1] = (i_count[0] == 1'b0);
                logical[2] = div3;
                logical[3] = (i_count[1:0] == 2'd0);
                logical[4] = div5;
                logical[5] = (i_count[0] == 1'b0) && div3;
                logical[6] = div7;
                logical[7] = (i_count[2:0] == 3'd0);
            end
        endcase
        rotated = {logical, logical} << i_rotation;
        o_gates = rotated[2*OUTPUT_COUNT-1:OUTPUT_COUNT];
    end

endmodule

// ===== test/rotating_clock_divider_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotating clock divider testbench
// Drives time steps into the divider through its valid/ready input channel
// and checks every result beat against a cycle-free model of the divider
// kept in this file. A short directed sequence covers the pulse, rotation and
// timer corner cases. Random phases then follow under several register
// settings, including the extremes of the pulse width and both divide modes.
// Both channels idle at random, apart from one long phase with no idling.
// ----------------------------------------------------------------------------
module rotating_clock_divider_test;
    import rcd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    t_cfg_index i_cfg_index;
    t_cfg_data  i_cfg_data;

    rcd_in_if  step_if ();
    rcd_out_if result_if ();

    rotating_clock_divider uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (step_if),
        .o_out       (result_if)
    );

    // Divider state as the block should hold it.
    t_divide_mode      mode_cfg;
    logic [TIME_W-1:0] width_cfg;
    logic [COUNT_W-1:0] pulse_count;
    logic [ROT_W-1:0]  rot_pos;
    logic [OUTPUT_COUNT-1:0] gate_levels;
    logic [TIME_W-1:0] width_left;
    logic              prev_rotate;

    int divisor_set [2][OUTPUT_COUNT] = '{
        '{1, 6, 8, 12, 24, 32, 48, 96},
        '{1, 2, 3, 4, 5, 6, 7, 8}
    };

    t_in_beat  pending_steps [$];
    t_out_beat expected_beats [$];

    int   cycle_count;
    int   mismatch_count;
    int   idle_pct;
    logic gen_rotate_level;
    int   steps_seen;
    int   pulses_seen;
    int   edges_seen;
    int   wraps_seen;
    int   expiries_seen;
    int   settings_seen;

    function automatic t_out_beat divide_step(t_in_beat s);
        logic [COUNT_W-1:0]      next_count;
        logic [OUTPUT_COUNT-1:0] g;
        int                      k;
        int                      pos;
        t_out_beat               r;
        steps_seen++;
        if (s.rotate_gate && !prev_rotate) begin
            rot_pos = rot_pos + 1'b1;
            edges_seen++;
        end
        prev_rotate = s.rotate_gate;
        if (s.clock_pulse) begin
            pulses_seen++;
            next_count = pulse_count + 1'b1;
            if (next_count >= COUNT_WRAP) begin
                next_count = '0;
                wraps_seen++;
            end
            pulse_count = next_count;
            width_left  = width_cfg;
            g = '0;
            for (k = 0; k < OUTPUT_COUNT; k++) begin
                pos = (k + int'(rot_pos)) % OUTPUT_COUNT;
                if (int'(pulse_count) % divisor_set[int'(mode_cfg)][k] == 0) begin
                    g[pos] = 1'b1;
                end
            end
            gate_levels = g;
        end else begin
            if (width_left != '0) begin
                width_left = (s.time_step >= width_left) ? '0 : width_left - s.time_step;
                if (width_left == '0) begin
                    expiries_seen++;
                end
            end
            if (width_left == '0) begin
                gate_levels = '0;
            end
        end
        r.gates        = gate_levels;
        r.pulse_number = pulse_count;
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic push_step(logic pulse, logic level, logic [TIME_W-1:0] ts);
        t_in_beat s;
        s.clock_pulse = pulse;
        s.rotate_gate = level;
        s.time_step   = ts;
        pending_steps.push_back(s);
        gen_rotate_level = level;
    endtask

    task automatic add_random_steps(int n);
        int   k;
        int   span;
        logic pulse;
        logic [TIME_W-1:0] ts;
        for (k = 0; k < n; k++) begin
            pulse = ($urandom_range(0, 99) < 55);
            if ($urandom_range(0, 99) < 30) begin
                gen_rotate_level = ~gen_rotate_level;
            end
            span = int'(width_cfg) / 4 + 2;
            if (span > 65535) begin
                span = 65535;
            end
            case ($urandom_range(0, 3))
                0: ts = TIME_W'($urandom);
                1: ts = TIME_W'($urandom_range(0, 3));
                default: ts = TIME_W'($urandom_range(0, span));
            endcase
            push_step(pulse, gen_rotate_level, ts);
        end
    endtask

    task automatic wait_until_idle();
        while (pending_steps.size() != 0 || expected_beats.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, t_cfg_data val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_DIVIDE_MODE: mode_cfg  = t_divide_mode'(val[0]);
            CFG_PULSE_WIDTH: width_cfg = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(t_divide_mode m, t_cfg_data w, int n, int pct);
        wait_until_idle();
        write_register(CFG_DIVIDE_MODE, t_cfg_data'(m));
        write_register(CFG_PULSE_WIDTH, w);
        settings_seen++;
        idle_pct = pct;
        add_random_steps(n);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d beats outstanding", cycle_count,
                     expected_beats.size());
            $display("Verification failed");
            $finish;
        end
    end

    // Step driver: holds a presented beat until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            step_if.valid <= 1'b0;
        end else begin
            if (step_if.valid && step_if.ready) begin
                expected_beats.push_back(divide_step(step_if.data));
                void'(pending_steps.pop_front());
            end
            if (step_if.valid && !step_if.ready) begin
            end else if (pending_steps.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                step_if.valid <= 1'b1;
                step_if.data  <= pending_steps[0];
            end else begin
                step_if.valid <= 1'b0;
            end
        end
    end

    // Result monitor with random back-pressure.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(0, 99) >= idle_pct);
            if (result_if.valid && result_if.ready) begin
                if (expected_beats.size() == 0) begin
                    report_mismatch($sformatf("result beat gates=%02h count=%0d not expected",
                                              result_if.data.gates,
                                              result_if.data.pulse_number));
                end else begin
                    want = expected_beats.pop_front();
                    if (result_if.data.gates !== want.gates) begin
                        report_mismatch($sformatf("gates %02h, expected %02h",
                                                  result_if.data.gates, want.gates));
                    end
                    if (result_if.data.pulse_number !== want.pulse_number) begin
                        report_mismatch($sformatf("pulse number %0d, expected %0d",
                                                  result_if.data.pulse_number,
                                                  want.pulse_number));
                    end
                end
            end
        end
    end

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_DIVIDE_MODE;
        i_cfg_data       = '0;
        step_if.valid    = 1'b0;
        step_if.data     = '0;
        result_if.ready  = 1'b0;
        cycle_count      = 0;
        mismatch_count   = 0;
        idle_pct         = 27;
        gen_rotate_level = 1'b0;
        steps_seen       = 0;
        pulses_seen      = 0;
        edges_seen       = 0;
        wraps_seen       = 0;
        expiries_seen    = 0;
        settings_seen    = 1;
        mode_cfg         = MODE_PPQN24;
        width_cfg        = PULSE_WIDTH_RESET;
        pulse_count      = '0;
        rot_pos          = '0;
        gate_levels      = '0;
        width_left       = '0;
        prev_rotate      = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed steps under the reset settings.
        push_step(1'b0, 1'b0, 16'd0);
        push_step(1'b1, 1'b0, 16'd0);
        push_step(1'b0, 1'b0, 16'd10);
        push_step(1'b0, 1'b1, 16'd0);
        push_step(1'b1, 1'b1, 16'hFFFF);
        push_step(1'b0, 1'b0, 16'd500);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b0, 1'b1, 16'd999);
        push_step(1'b0, 1'b1, 16'd1);
        push_step(1'b0, 1'b0, 16'hFFFF);
        push_step(1'b1, 1'b0, 16'hFFFF);
        push_step(1'b0, 1'b0, 16'hFFFF);
        push_step(1'b1, 1'b1, 16'h5555);
        push_step(1'b1, 1'b0, 16'hAAAA);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b1, 1'b0, 16'd0);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b1, 1'b0, 16'd0);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b1, 1'b0, 16'd0);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b0, 1'b1, 16'd0);

        // A zero pulse width clears the gates on the very next step.
        wait_until_idle();
        write_register(CFG_DIVIDE_MODE, t_cfg_data'(MODE_LINEAR));
        write_register(CFG_PULSE_WIDTH, 16'd0);
        settings_seen++;
        push_step(1'b1, 1'b0, 16'd0);
        push_step(1'b0, 1'b0, 16'd0);
        push_step(1'b1, 1'b1, 16'd0);
        push_step(1'b1, 1'b0, 16'd0);
        add_random_steps(110);

        run_phase(MODE_PPQN24, 16'hFFFF, 200, 0);
        run_phase(MODE_LINEAR, 16'd1, 150, 27);
        run_phase(MODE_PPQN24, t_cfg_data'($urandom_range(1, 65535)), 200, 27);
        run_phase(MODE_LINEAR, 16'hFFFF, 130, 27);
        run_phase(MODE_PPQN24, 16'd37, 130, 27);

        wait_until_idle();
        if (expected_beats.size() != 0) begin
            report_mismatch($sformatf("%0d result beats never arrived", expected_beats.size()));
        end

        $display("Checked %0d time steps under %0d register settings: %0d pulses, %0d rotations",
                 steps_seen, settings_seen, pulses_seen, edges_seen);
        $display("Pulse count wrapped %0d times, pulse timer expired %0d times, %0d mismatches",
                 wraps_seen, expiries_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/rcd_pkg.sv
src/rcd_if.sv
src/rcd_gate_calc.sv
src/rotating_clock_divider.sv
test/rotating_clock_divider_test.sv
